// ===== src/nth_ugly_number_defines.svh =====
// Assertion macros for the nth_ugly_number block.
// No dependencies; assumes the including module has clock and reset.
`ifndef NTH_UGLY_NUMBER_DEFINES_SVH
`define NTH_UGLY_NUMBER_DEFINES_SVH

// same-cycle implication, idle during reset
`define NUN_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, idle during reset
`define NUN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/nun_pkg.sv =====
// Types and constants for the nth_ugly_number block.
// No dependencies.
`timescale 1ns / 1ps

package nun_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FETCH,
      ST_LATCH
   } state_type;

   localparam logic [2:0] FACTOR_TWO   = 3'd2;
   localparam logic [2:0] FACTOR_THREE = 3'd3;
   localparam logic [2:0] FACTOR_FIVE  = 3'd5;

   localparam logic [31:0] FIRST_VALUE = 32'd1;

   localparam logic [2:0] SEL_TWO   = 3'b001;
   localparam logic [2:0] SEL_THREE = 3'b010;
   localparam logic [2:0] SEL_FIVE  = 3'b100;

endpackage

// ===== src/nth_ugly_number.sv =====
// An index of 0 or above MAX_N answers in the cycle after acceptance.
// A valid index n answers once the table holds its first n entries: each entry is appended
// in ST_STEP, then each pointer that advanced for it (1 to 3 of them) reloads its value
// through ST_FETCH and ST_LATCH one at a time, as the sequence table has a single read port.
// One word at a time: no new word is taken until the result register is free.
// Reset clears the sequencer, pointers and result valid; table contents stay.
`timescale 1ns / 1ps
`include "nth_ugly_number_defines.svh"

module nth_ugly_number #(
   parameter int MAX_N = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_index_n,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_ugly_value,
   output logic        rsp_range_error
);

   localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CW = $clog2(MAX_N + 1);

   nun_pkg::state_type state_ff, state_in;

   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] ptr2_ff, ptr2_in;
   logic [AW-1:0] ptr3_ff, ptr3_in;
   logic [AW-1:0] ptr5_ff, ptr5_in;
   logic [31:0]   val2_ff, val2_in;
   logic [31:0]   val3_ff, val3_in;
   logic [31:0]   val5_ff, val5_in;
   logic [31:0]   last_ff, last_in;
   logic [2:0]    pend_ff, pend_in;
   logic [2:0]    sel_ff, sel_in;
   logic [31:0]   rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_error_ff, rsp_error_in;

   logic [31:0] mem [MAX_N];

   logic          req_fire;
   logic          req_bad;
   logic [34:0]   prod2, prod3, prod5;
   logic [34:0]   min23, next_val;
   logic [2:0]    hit;
   logic [2:0]    low;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   assign req_ready       = (state_ff == nun_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire        = req_valid && req_ready;
   assign req_bad         = (req_index_n == 16'd0) || (req_index_n > 16'(MAX_N));
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ugly_value  = rsp_value_ff;
   assign rsp_range_error = rsp_error_ff;

   assign prod2    = 35'(val2_ff) * 35'(nun_pkg::FACTOR_TWO);
   assign prod3    = 35'(val3_ff) * 35'(nun_pkg::FACTOR_THREE);
   assign prod5    = 35'(val5_ff) * 35'(nun_pkg::FACTOR_FIVE);
   assign min23    = (prod3 < prod2) ? prod3 : prod2;
   assign next_val = (prod5 < min23) ? prod5 : min23;
   assign hit      = {prod5 == next_val, prod3 == next_val, prod2 == next_val};
   assign low      = pend_ff & (~pend_ff + 3'd1);

   always_comb begin
      case (low)
         nun_pkg::SEL_TWO:   rd_addr = ptr2_ff;
         nun_pkg::SEL_THREE: rd_addr = ptr3_ff;
         nun_pkg::SEL_FIVE:  rd_addr = ptr5_ff;
         default:            rd_addr = ptr2_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nun_pkg::ST_IDLE: begin
            if (req_fire && !req_bad) state_in = nun_pkg::ST_STEP;
         end
         nun_pkg::ST_STEP: begin
            state_in = (idx_ff == n_ff) ? nun_pkg::ST_IDLE : nun_pkg::ST_FETCH;
         end
         nun_pkg::ST_FETCH: begin
            state_in = nun_pkg::ST_LATCH;
         end
         nun_pkg::ST_LATCH: begin
            if (pend_ff == 3'b000) state_in = nun_pkg::ST_STEP;
         end
         default: state_in = nun_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      n_in         = n_ff;
      idx_in       = idx_ff;
      ptr2_in      = ptr2_ff;
      ptr3_in      = ptr3_ff;
      ptr5_in      = ptr5_ff;
      val2_in      = val2_ff;
      val3_in      = val3_ff;
      val5_in      = val5_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = next_val[31:0];
      case (state_ff)
         nun_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_error_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = nun_pkg::FIRST_VALUE;
                  val2_in = nun_pkg::FIRST_VALUE;
                  val3_in = nun_pkg::FIRST_VALUE;
                  val5_in = nun_pkg::FIRST_VALUE;
                  last_in = nun_pkg::FIRST_VALUE;
                  ptr2_in = '0;
                  ptr3_in = '0;
                  ptr5_in = '0;
                  idx_in  = CW'(1);
                  n_in    = req_index_n[CW-1:0];
               end
            end
         end
         nun_pkg::ST_STEP: begin
            if (idx_ff == n_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = last_ff;
               rsp_error_in = 1'b0;
            end else begin
               wr_en   = 1'b1;
               last_in = next_val[31:0];
               pend_in = hit;
               ptr2_in = ptr2_ff + AW'(hit[0]);
               ptr3_in = ptr3_ff + AW'(hit[1]);
               ptr5_in = ptr5_ff + AW'(hit[2]);
               idx_in  = idx_ff + CW'(1);
            end
         end
         nun_pkg::ST_FETCH: begin
            sel_in  = low;
            pend_in = pend_ff & ~low;
         end
         nun_pkg::ST_LATCH: begin
            if (sel_ff[0]) val2_in = rd_data_ff;
            if (sel_ff[1]) val3_in = rd_data_ff;
            if (sel_ff[2]) val5_in = rd_data_ff;
            sel_in  = low;
            pend_in = pend_ff & ~low;
         end
         default: begin
            pend_in = 3'b000;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nun_pkg::ST_IDLE;
         idx_ff       <= '0;
         n_ff         <= '0;
         ptr2_ff      <= '0;
         ptr3_ff      <= '0;
         ptr5_ff      <= '0;
         pend_ff      <= 3'b000;
         sel_ff       <= 3'b000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         ptr2_ff      <= ptr2_in;
         ptr3_ff      <= ptr3_in;
         ptr5_ff      <= ptr5_in;
         pend_ff      <= pend_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val2_ff      <= val2_in;
      val3_ff      <= val3_in;
      val5_ff      <= val5_in;
      last_ff      <= last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   `NUN_ASSERT_SAME(a_error_value_zero,
      rsp_valid && rsp_range_error,
      rsp_ugly_value == 32'd0,
      "flagged word carries a nonzero value")
   `NUN_ASSERT_NEXT(a_step_advances,
      state_ff == nun_pkg::ST_STEP && idx_ff != n_ff,
      pend_ff != 3'b000 && idx_ff == $past(idx_ff) + CW'(1),
      "step appended an entry without advancing a pointer")
   `NUN_ASSERT_SAME(a_ptr_below_fill,
      state_ff == nun_pkg::ST_STEP,
      CW'(ptr2_ff) < idx_ff && CW'(ptr3_ff) < idx_ff && CW'(ptr5_ff) < idx_ff,
      "pointer reaches an unwritten entry")
   `NUN_ASSERT_SAME(a_latch_sel_onehot,
      state_ff == nun_pkg::ST_LATCH,
      $onehot(sel_ff),
      "latch without exactly one selected pointer")

endmodule

// ===== test/nth_ugly_number_test.sv =====
// Self-checking testbench for nth_ugly_number: sends index words, rebuilds the sequence
// in a local table to predict each answer, and compares every result word in order.
// Depends on nun_pkg and the nth_ugly_number RTL.
`timescale 1ns / 1ps

module nth_ugly_number_test;

   localparam int MAX_N = 1024;
   localparam int RANDOM_ITEMS = 560;
   localparam int DRAIN_CYCLES = 16;
   localparam longint CYCLE_LIMIT = 4 * (RANDOM_ITEMS + 60) * (5 * MAX_N + 30);

   typedef struct {
      logic [15:0] index;
      logic [31:0] value;
      logic        flag;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_index_n;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_ugly_value;
   logic        rsp_range_error;

   logic [31:0] ugly_table [0:MAX_N-1];
   logic [9:0]  next_by_two;
   logic [9:0]  next_by_three;
   logic [9:0]  next_by_five;

   answer_type pending_answers [$];
   bit      quiet = 1'b0;
   int      mismatch_count = 0;
   int      checked_count = 0;
   int      in_range_count = 0;
   int      out_of_range_count = 0;
   int      largest_index = 0;
   longint  cycle_count = 0;

   nth_ugly_number #(.MAX_N(MAX_N)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_index_n(req_index_n),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ugly_value(rsp_ugly_value),
      .rsp_range_error(rsp_range_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers pending", cycle_count,
                  pending_answers.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void predict_answer(input logic [15:0] n, output answer_type ans);
      logic [63:0] by_two;
      logic [63:0] by_three;
      logic [63:0] by_five;
      logic [63:0] smallest;
      int i;
      ans.index = n;
      if (n == 16'd0 || n > MAX_N) begin
         ans.value = '0;
         ans.flag = 1'b1;
         return;
      end
      ugly_table[0] = nun_pkg::FIRST_VALUE;
      next_by_two = '0;
      next_by_three = '0;
      next_by_five = '0;
      for (i = 1; i < n; i++) begin
         by_two = {32'd0, ugly_table[next_by_two]} * nun_pkg::FACTOR_TWO;
         by_three = {32'd0, ugly_table[next_by_three]} * nun_pkg::FACTOR_THREE;
         by_five = {32'd0, ugly_table[next_by_five]} * nun_pkg::FACTOR_FIVE;
         smallest = by_two;
         if (by_three < smallest) smallest = by_three;
         if (by_five < smallest) smallest = by_five;
         ugly_table[10'(i)] = smallest[31:0];
         if (by_two == smallest) next_by_two++;
         if (by_three == smallest) next_by_three++;
         if (by_five == smallest) next_by_five++;
      end
      ans.value = ugly_table[10'(n - 16'd1)];
      ans.flag = 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input answer_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s) n=%0d: expected value=%0d error=%0b, got value=%0d error=%0b",
                  what, want.index, want.value, want.flag, rsp_ugly_value, rsp_range_error);
   endtask

   task automatic send_index(input logic [15:0] n);
      int gap;
      answer_type ans;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_index_n <= n;
      do @(posedge clock); while (!req_ready);
      predict_answer(n, ans);
      pending_answers.push_back(ans);
      if (ans.flag) out_of_range_count++;
      else in_range_count++;
      if (!ans.flag && n > largest_index) largest_index = int'(n);
   endtask

   // result side: draw a stall per word, then take and check it
   initial begin
      int stall;
      answer_type want;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         checked_count++;
         if (pending_answers.size() == 0) begin
            want.index = 'x;
            want.value = 'x;
            want.flag = 'x;
            note_mismatch("no word pending", want);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_ugly_value !== want.value || rsp_range_error !== want.flag)
               note_mismatch("field", want);
         end
      end
   end

   task automatic test_first_terms();
      int n;
      for (n = 1; n <= 10; n++) send_index(n[15:0]);
   endtask

   // values where two or three pointers advance together: 6, 10, 30
   task automatic test_pointer_ties();
      send_index(16'd6);
      send_index(16'd9);
      send_index(16'd18);
   endtask

   task automatic test_range_limits();
      send_index(16'd0);
      send_index(MAX_N[15:0]);
      send_index(MAX_N[15:0] + 16'd1);
      send_index(MAX_N[15:0] - 16'd1);
      send_index(16'hFFFF);
      send_index(16'h8000);
      send_index(16'd1);
   endtask

   task automatic test_random_queries(input int count);
      int i;
      int pick;
      logic [15:0] n;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 68) n = 16'($urandom_range(1, 80));
         else if (pick < 82) n = 16'($urandom_range(81, MAX_N));
         else if (pick < 85) n = MAX_N[15:0];
         else if (pick < 88) n = 16'd0;
         else n = 16'($urandom_range(MAX_N + 1, 65535));
         send_index(n);
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_index_n <= '0;
      next_by_two = '0;
      next_by_three = '0;
      next_by_five = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_terms();
      test_pointer_ties();
      test_range_limits();
      test_random_queries(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d in-range and %0d out-of-range indexes, largest index %0d",
               in_range_count, out_of_range_count, largest_index);
      $display("checked %0d result words in %0d cycles, %0d mismatches",
               checked_count, cycle_count, mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
